FILE: src/sample_set_statistics_core_assert.svh
// Assertion macros used by the statistics core checker.
`ifndef SAMPLE_SET_STATISTICS_CORE_ASSERT_SVH
`define SAMPLE_SET_STATISTICS_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/sss_pkg.sv
// Package with widths, payload types and controller types of the statistics core.
`timescale 1ns / 1ps
`default_nettype none
package sss_pkg;
	localparam int SAMPLE_W  = 16;
	localparam int COUNT_W   = 17;
	localparam int FRAC_W    = 8;
	localparam int SUM_W     = SAMPLE_W + COUNT_W;
	localparam int SQ_W      = 2 * SAMPLE_W + COUNT_W - 2;
	localparam int MEAN_W    = SAMPLE_W + FRAC_W;
	localparam int STD_W     = 24;
	localparam int MAG_W     = SUM_W - 1;
	localparam int PROD_W    = 64;
	localparam int SPLIT_W   = 24;
	localparam int DEN_W     = 32;
	localparam int D_W       = 63;
	localparam int DIV_NUM_W = D_W + 2 * FRAC_W;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W);
	localparam int ROOT_IN_W = 48;
	localparam int ROOT_W    = ROOT_IN_W / 2;
	localparam int ROOT_CNT_W = $clog2(ROOT_W);
	localparam int REM_W     = ROOT_W + 2;

	localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(65536);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       is_last;
	} in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] max_value;
		logic signed [SAMPLE_W-1:0] min_value;
		logic signed [MEAN_W-1:0]   mean_q8;
		logic [STD_W-1:0]           std_dev_q8;
		logic [COUNT_W-1:0]         sample_count;
		logic                       single_sample;
		logic                       count_overflow;
	} out_t;

	typedef enum logic [3:0] {
		ST_ACCUM,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_DIFF,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_VAR_GO,
		ST_VAR_WAIT,
		ST_ROOT_GO,
		ST_ROOT_WAIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic accum;
		logic mul_lo;
		logic mul_hi;
		logic diff;
		logic mean_start;
		logic mean_capture;
		logic var_start;
		logic root_start;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic root_busy;
	} status_t;
endpackage
`default_nettype wire

FILE: src/sss_in_if.sv
// Sample channel interface carrying valid, ready and one sample.
`timescale 1ns / 1ps
`default_nettype none
interface sss_in_if;
	import sss_pkg::*;
	logic valid;
	logic ready;
	in_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/sss_out_if.sv
// Result channel interface carrying valid, ready and one statistics record.
`timescale 1ns / 1ps
`default_nettype none
interface sss_out_if;
	import sss_pkg::*;
	logic valid;
	logic ready;
	out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/sss_divider.sv
// Restoring unsigned divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module sss_divider (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [sss_pkg::DIV_NUM_W-1:0] num,
	input  wire logic [sss_pkg::DEN_W-1:0]     den,
	output logic                                busy,
	output logic [sss_pkg::DIV_NUM_W-1:0]      quot,
	output logic [sss_pkg::DEN_W-1:0]          rem
);
	import sss_pkg::*;

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DEN_W-1:0]     den_q;
	logic [DEN_W:0]       shifted;
	logic                 fits;

	// Bring down the next dividend bit and try the subtraction.
	assign shifted = {rem_q, quo_q[DIV_NUM_W-1]};
	assign fits    = shifted >= {1'b0, den_q};

	// Control: busy flag and bit counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DIV_NUM_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Data: partial remainder and dividend that fills with quotient bits.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
			rem_q <= fits ? DEN_W'(shifted - {1'b0, den_q}) : shifted[DEN_W-1:0];
		end
	end

	assign busy = busy_q;
	assign quot = quo_q;
	assign rem  = rem_q;
endmodule
`default_nettype wire

FILE: src/sss_isqrt.sv
// Digit-by-digit integer square root that settles one root bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module sss_isqrt (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [sss_pkg::ROOT_IN_W-1:0] radicand,
	output logic                                busy,
	output logic [sss_pkg::ROOT_W-1:0]         root
);
	import sss_pkg::*;

	logic                  busy_q;
	logic [ROOT_CNT_W-1:0] cnt_q;
	logic [ROOT_IN_W-1:0]  x_q;
	logic [REM_W-1:0]      r_q;
	logic [ROOT_W-1:0]     y_q;
	logic [REM_W+1:0]      r_shift;
	logic [REM_W+1:0]      trial;
	logic                  fits;

	// Append the next two radicand bits and test the trial subtrahend.
	assign r_shift = {r_q, x_q[ROOT_IN_W-1 -: 2]};
	assign trial   = (REM_W + 2)'({y_q, 2'b01});
	assign fits    = r_shift >= trial;

	// Control: busy flag and step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= ROOT_CNT_W'(ROOT_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Data: radicand shift register, partial remainder and root.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= radicand;
			r_q <= '0;
			y_q <= '0;
		end else if (busy_q) begin
			x_q <= {x_q[ROOT_IN_W-3:0], 2'b00};
			r_q <= fits ? REM_W'(r_shift - trial) : r_shift[REM_W-1:0];
			y_q <= {y_q[ROOT_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign root = y_q;
endmodule
`default_nettype wire

FILE: src/sss_datapath.sv
// Accumulators, final arithmetic and result register of the statistics core.
`timescale 1ns / 1ps
`default_nettype none
module sss_datapath (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire sss_pkg::cmd_t   cmd,
	input  wire sss_pkg::in_t    item,
	output sss_pkg::status_t     status,
	output sss_pkg::out_t        result
);
	import sss_pkg::*;

	logic [COUNT_W-1:0]         count_q;
	logic signed [SAMPLE_W-1:0] max_q;
	logic signed [SAMPLE_W-1:0] min_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic [SQ_W-1:0]            sumsq_q;
	logic                       ovf_q;

	logic [PROD_W-1:0]          nss_q;
	logic [PROD_W-1:0]          magsq_q;
	logic [DEN_W-1:0]           den_q;
	logic [D_W-1:0]             d_q;
	logic signed [MEAN_W-1:0]   mean_q;
	out_t                       result_q;

	logic [2*SAMPLE_W-1:0]      square;
	logic [SUM_W-1:0]           sum_neg;
	logic [MAG_W-1:0]           mag;
	logic [COUNT_W+SPLIT_W-1:0] prod_lo;
	logic [PROD_W-SPLIT_W-1:0]  prod_hi;
	logic [2*COUNT_W-1:0]       pair_count;

	logic                       div_start;
	logic [DIV_NUM_W-1:0]       div_num;
	logic [DEN_W-1:0]           div_den;
	logic                       div_busy;
	logic [DIV_NUM_W-1:0]       div_quot;
	logic [DEN_W-1:0]           div_rem;
	logic                       root_busy;
	logic [ROOT_W-1:0]          root;
	logic [MEAN_W-1:0]          mean_mag;

	// Square of the incoming sample for the sum of squares.
	assign square = (2*SAMPLE_W)'($unsigned(32'(item.sample) * 32'(item.sample)));

	// Running accumulators, cleared once the result has been loaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			max_q   <= '0;
			min_q   <= '0;
			sum_q   <= '0;
			sumsq_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.load_out) begin
			count_q <= '0;
			max_q   <= '0;
			min_q   <= '0;
			sum_q   <= '0;
			sumsq_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.accum) begin
			if (count_q == MAX_COUNT) begin
				ovf_q <= 1'b1;
			end else begin
				if (count_q == '0 || item.sample > max_q) begin
					max_q <= item.sample;
				end
				if (count_q == '0 || item.sample < min_q) begin
					min_q <= item.sample;
				end
				sum_q   <= sum_q + SUM_W'(item.sample);
				sumsq_q <= sumsq_q + SQ_W'(square);
				count_q <= count_q + 1'b1;
			end
		end
	end

	// Magnitude of the sum and the partial products of the final step.
	assign sum_neg    = SUM_W'(-sum_q);
	assign mag        = sum_q[SUM_W-1] ? sum_neg[MAG_W-1:0] : sum_q[MAG_W-1:0];
	assign prod_lo    = (COUNT_W + SPLIT_W)'(count_q) * (COUNT_W + SPLIT_W)'(sumsq_q[SPLIT_W-1:0]);
	assign prod_hi    = (PROD_W - SPLIT_W)'(count_q) * (PROD_W - SPLIT_W)'(sumsq_q[SQ_W-1:SPLIT_W]);
	assign pair_count = (2*COUNT_W)'(count_q) * (2*COUNT_W)'(count_q - 1'b1);

	// n*sumsq in two halves, sum squared, n*(n-1), then the difference.
	always_ff @(posedge clk) begin
		if (cmd.mul_lo) begin
			nss_q   <= PROD_W'(prod_lo);
			magsq_q <= PROD_W'(mag) * PROD_W'(mag);
			den_q   <= pair_count[DEN_W-1:0];
		end else if (cmd.mul_hi) begin
			nss_q <= nss_q + {prod_hi, {SPLIT_W{1'b0}}};
		end
		if (cmd.diff) begin
			d_q <= D_W'(nss_q - magsq_q);
		end
	end

	// The shared divider serves the mean first and the variance second.
	assign div_start = cmd.mean_start | cmd.var_start;
	assign div_num   = cmd.var_start ? {d_q, {(2*FRAC_W){1'b0}}}
	                                 : DIV_NUM_W'({mag, {FRAC_W{1'b0}}});
	assign div_den   = cmd.var_start ? den_q : DEN_W'(count_q);

	sss_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	sss_isqrt u_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.root_start),
		.radicand (div_quot[ROOT_IN_W-1:0]),
		.busy     (root_busy),
		.root     (root)
	);

	// Floored mean: a negative sum rounds its magnitude up when inexact.
	assign mean_mag = div_quot[MEAN_W-1:0] + MEAN_W'(sum_q[SUM_W-1] && (div_rem != '0));

	always_ff @(posedge clk) begin
		if (cmd.mean_capture) begin
			mean_q <= sum_q[SUM_W-1] ? MEAN_W'(-mean_mag) : mean_mag;
		end
	end

	// Result register, loaded when the output side is free.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			result_q.max_value      <= max_q;
			result_q.min_value      <= min_q;
			result_q.mean_q8        <= mean_q;
			result_q.std_dev_q8     <= (count_q == COUNT_W'(1)) ? '0 : STD_W'(root);
			result_q.sample_count   <= count_q;
			result_q.single_sample  <= (count_q == COUNT_W'(1));
			result_q.count_overflow <= ovf_q;
		end
	end

	assign status.div_busy  = div_busy;
	assign status.root_busy = root_busy;
	assign result           = result_q;
endmodule
`default_nettype wire

FILE: src/sss_controller.sv
// Sequencer that steps the datapath through accumulation and the final arithmetic.
`timescale 1ns / 1ps
`default_nettype none
module sss_controller (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_last,
	input  wire logic             out_ready,
	input  wire sss_pkg::status_t status,
	output logic                  in_ready,
	output logic                  out_valid,
	output sss_pkg::cmd_t         cmd
);
	import sss_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCUM;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_ACCUM: begin
				if (in_valid && in_last) state_d = ST_MUL_LO;
			end
			ST_MUL_LO:    state_d = ST_MUL_HI;
			ST_MUL_HI:    state_d = ST_DIFF;
			ST_DIFF:      state_d = ST_MEAN_GO;
			ST_MEAN_GO:   state_d = ST_MEAN_WAIT;
			ST_MEAN_WAIT: begin
				if (!status.div_busy) state_d = ST_VAR_GO;
			end
			ST_VAR_GO:    state_d = ST_VAR_WAIT;
			ST_VAR_WAIT: begin
				if (!status.div_busy) state_d = ST_ROOT_GO;
			end
			ST_ROOT_GO:   state_d = ST_ROOT_WAIT;
			ST_ROOT_WAIT: begin
				if (!status.root_busy) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_d = ST_ACCUM;
			end
			default:      state_d = ST_ACCUM;
		endcase
	end

	// Outputs: handshake and datapath commands.
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_ACCUM: begin
				in_ready  = 1'b1;
				cmd.accum = in_valid;
			end
			ST_MUL_LO:    cmd.mul_lo = 1'b1;
			ST_MUL_HI:    cmd.mul_hi = 1'b1;
			ST_DIFF:      cmd.diff = 1'b1;
			ST_MEAN_GO:   cmd.mean_start = 1'b1;
			ST_MEAN_WAIT: cmd.mean_capture = !status.div_busy;
			ST_VAR_GO:    cmd.var_start = 1'b1;
			ST_VAR_WAIT:  cmd = '0;
			ST_ROOT_GO:   cmd.root_start = 1'b1;
			ST_ROOT_WAIT: cmd = '0;
			ST_FINISH:    cmd.load_out = out_free;
			default:      cmd = '0;
		endcase
	end

	// Result valid flag: set on load, cleared when the transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

FILE: src/sample_set_statistics_core.sv
// Top level of the sample set statistics core: min, max, mean and deviation.
//
//   channel   direction  payload                                       handshake
//   samples   sink       sample (s16), is_last                         valid/ready
//   stats     source     max, min, mean_q8, std_dev_q8, count, flags   valid/ready
//
// Ready is high whenever no set is being closed. The last sample of a set starts the
// finishing work before the result is offered: two waits on the bit-serial divider
// (79 quotient bits each), one on the 24-step square root and the sequencing states.
// Reset clears all accumulators and the result valid flag at once.
// A held result stalls only the loading of the next one; no samples are taken while that load waits.
`timescale 1ns / 1ps
`default_nettype none
module sample_set_statistics_core (
	input wire logic clk,
	input wire logic arst_n,
	sss_in_if.sink   samples,
	sss_out_if.source stats
);
	import sss_pkg::*;

	cmd_t    cmd;
	status_t status;
	out_t    result;
	logic    out_valid;
	logic    in_ready;

	sss_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_last   (samples.data.is_last),
		.out_ready (stats.ready),
		.status    (status),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	sss_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (samples.data),
		.status (status),
		.result (result)
	);

	assign samples.ready = in_ready;
	assign stats.valid   = out_valid;
	assign stats.data    = result;
endmodule
`default_nettype wire

FILE: src/sss_checker.sv
// Port-level checker for the statistics core and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
`include "sample_set_statistics_core_assert.svh"
module sss_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          res_valid,
	input wire logic          res_ready,
	input wire sss_pkg::out_t res_data
);
	import sss_pkg::*;

	// A stalled result must stay offered and unchanged.
	`SSS_ASSERT_NEXT(a_hold, res_valid && !res_ready, res_valid && $stable(res_data), "result changed while stalled")

	// The single-sample flag tracks a count of one.
	`SSS_ASSERT_NOW(a_single, res_valid, res_data.single_sample == (res_data.sample_count == COUNT_W'(1)), "single flag disagrees with count")

	// A single sample has no deviation.
	`SSS_ASSERT_NOW(a_single_std, res_valid && res_data.single_sample, res_data.std_dev_q8 == '0, "deviation non-zero for one sample")

	// The maximum never lies below the minimum.
	`SSS_ASSERT_NOW(a_order, res_valid, res_data.max_value >= res_data.min_value, "maximum below minimum")
endmodule

bind sample_set_statistics_core sss_checker u_sss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (stats.valid),
	.res_ready (stats.ready),
	.res_data  (stats.data)
);
`default_nettype wire
